// ===== design/emlts_pkg.sv =====
`default_nettype none

package emlts_pkg;

	// defaults for the top-level parameters
	localparam int CITIES_DEF     = 8;
	localparam int COUNT_BITS_DEF = 10;

	// random fraction width is fixed by the input field
	localparam int RANDOM_BITS = 16;

	// item kinds carried in tuser
	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LEARN = 2'd1,
		MODE_START = 2'd2,
		MODE_NEXT  = 2'd3
	} mode_t;

	// accumulator control from the sequencer
	typedef struct packed {
		logic clr;
		logic add;
	} acc_ctl_t;

endpackage

`default_nettype wire

// ===== design/emlts_ram.sv =====
`default_nettype none

module emlts_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/emlts_acc.sv =====
`default_nettype none

// Shared running-sum unit: sums row counts, and tests
// prod <= (sum + data) * (2^RANDOM_BITS - 1) for the cumulative walk.
module emlts_acc
	import emlts_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int CITY_W     = 3
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  acc_ctl_t                                  ctl,
	input  wire [COUNT_BITS-1:0]                      data,
	input  wire [COUNT_BITS+CITY_W+RANDOM_BITS-1:0]   prod,
	output logic [COUNT_BITS+CITY_W-1:0]              sum,
	output logic                                      hit
);

	localparam int TW = COUNT_BITS + CITY_W;
	localparam int PW = TW + RANDOM_BITS;

	logic [TW-1:0] acc_q;
	logic [TW-1:0] cum_next;
	logic [PW-1:0] cum_scaled;

	assign cum_next   = acc_q + TW'(data);
	// cum * (2^R - 1) as shift and subtract
	assign cum_scaled = {cum_next, {RANDOM_BITS{1'b0}}} - PW'(cum_next);
	assign hit        = (prod <= cum_scaled);
	assign sum        = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= cum_next;
		end
	end

endmodule

`default_nettype wire

// ===== design/edge_model_learn_and_tour_sample.sv =====
`default_nettype none

// Edge-histogram tour model with a sampler.
// Input stream (s_axis): tuser = item kind (clear, learn city, start tour,
// sample next), tdata = city and random fraction, tlast = last city of a
// learned tour. Output stream (m_axis): one transfer for each start or
// sample-next item, tdata = chosen city, tlast = every city now visited.
// Clear and learn items produce no output transfer.
// Counts live in a CITIES*CITIES RAM with one write and one read port.
// Work per item, accept to next tready (the result is offered as tready returns):
//   clear       the clearing pass, one RAM word written per cycle
//   learn       a RAM read and a RAM write per count bumped (up to 2 bumps)
//   start       straight to the finish state
//   sample next the row is streamed through the one RAM read port twice,
//               once to sum the unvisited counts, once for the cumulative
//               compare, with a multiply state between the passes. A hit
//               stops the second pass early.
// Reset: the block runs the clearing pass before tready first rises;
// learn and sampling state start at zero.
// Output stall: the result register holds a finished result while the next
// item is accepted; a second result waits in the sequencer until it drains.
module edge_model_learn_and_tour_sample
	import emlts_pkg::*;
#(
	parameter int CITIES     = CITIES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [23:0]  s_axis_tdata,  // city[2:0], random_value[18:3], zero fill
	input  wire [1:0]   s_axis_tuser,  // mode[1:0]
	input  wire         s_axis_tlast,  // tour_end
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // chosen_city[2:0], zero fill
	output logic        m_axis_tlast   // tour_complete
);

	localparam int CW    = (CITIES > 1) ? $clog2(CITIES) : 1;
	localparam int DEPTH = CITIES * CITIES;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = COUNT_BITS + CW;
	localparam int PW    = TW + RANDOM_BITS;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LRD,
		S_LWR,
		S_SUM,
		S_MUL,
		S_WALK,
		S_DONE
	} state_t;

	state_t state_q;

	logic [AW-1:0]          clr_idx_q;
	logic [CW-1:0]          first_q;
	logic [CW-1:0]          prev_q;
	logic                   in_tour_q;
	logic [AW-1:0]          addr_q;
	logic [AW-1:0]          addr_b_q;
	logic                   pend_b_q;
	logic [CW-1:0]          cur_q;
	logic [CITIES-1:0]      visited_q;
	logic [RANDOM_BITS-1:0] rv_q;
	logic [PW-1:0]          prod_q;
	logic [CW-1:0]          iss_q;
	logic                   iss_act_q;
	logic                   v_s1;
	logic [CW-1:0]          j_s1;
	logic [CW-1:0]          ff_q;
	logic                   ff_found_q;
	logic [2:0]             res_city_q;
	logic                   res_last_q;
	logic                   m_valid_q;
	logic [2:0]             m_city_q;
	logic                   m_last_q;

	logic                   in_fire;
	mode_t                  in_mode;
	logic [CW-1:0]          c_in;
	logic [CW-1:0]          first_eff;
	logic [CITIES-1:0]      start_mask;
	logic                   unvisited_s1;
	logic                   pick_now;
	logic [CW-1:0]          pick_c;
	logic [CITIES-1:0]      visited_new;
	logic                   out_load;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_BITS-1:0]  ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [COUNT_BITS-1:0]  ram_rdata;
	logic [COUNT_BITS-1:0]  bumped;

	acc_ctl_t               acc_ctl;
	logic [TW-1:0]          acc_sum;
	logic                   acc_hit;

	function automatic logic [AW-1:0] pair_addr(input logic [CW-1:0] from_c,
			input logic [CW-1:0] to_c);
		pair_addr = AW'(AW'(from_c) * AW'(CITIES)) + AW'(to_c);
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_mode       = mode_t'(s_axis_tuser);

	// city index wraps modulo CITIES: small constant table over the 3-bit field
	always_comb begin
		c_in = '0;
		for (int i = 0; i < 8; i++) begin
			if (s_axis_tdata[2:0] == 3'(i)) begin
				c_in = CW'(i % CITIES);
			end
		end
	end

	assign first_eff  = in_tour_q ? first_q : c_in;
	assign start_mask = CITIES'(1) << c_in;

	// sampling walk
	assign unvisited_s1 = v_s1 && !visited_q[j_s1];
	always_comb begin
		pick_now = 1'b0;
		pick_c   = ff_q;
		if (unvisited_s1 && acc_hit) begin
			pick_now = 1'b1;
			pick_c   = j_s1;
		end else if (v_s1 && (j_s1 == CW'(CITIES - 1))) begin
			pick_now = 1'b1;
		end
	end
	assign visited_new = visited_q | (CITIES'(1) << pick_c);

	assign acc_ctl.clr = (in_fire && (in_mode == MODE_NEXT)) || (state_q == S_MUL);
	assign acc_ctl.add = unvisited_s1 && ((state_q == S_SUM) || (state_q == S_WALK));

	// count RAM ports
	assign bumped    = (ram_rdata == {COUNT_BITS{1'b1}}) ? ram_rdata
	                 : ram_rdata + COUNT_BITS'(1);
	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_LWR);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_idx_q : addr_q;
	assign ram_wdata = (state_q == S_CLEAR) ? COUNT_BITS'(1) : bumped;
	assign ram_raddr = (state_q == S_LRD) ? addr_q : pair_addr(cur_q, iss_q);

	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	emlts_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	emlts_acc #(
		.COUNT_BITS (COUNT_BITS),
		.CITY_W     (CW)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.data   (ram_rdata),
		.prod   (prod_q),
		.sum    (acc_sum),
		.hit    (acc_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_idx_q  <= '0;
			first_q    <= '0;
			prev_q     <= '0;
			in_tour_q  <= 1'b0;
			addr_q     <= '0;
			addr_b_q   <= '0;
			pend_b_q   <= 1'b0;
			cur_q      <= '0;
			visited_q  <= '0;
			rv_q       <= '0;
			prod_q     <= '0;
			iss_q      <= '0;
			iss_act_q  <= 1'b0;
			v_s1       <= 1'b0;
			j_s1       <= '0;
			ff_q       <= '0;
			ff_found_q <= 1'b0;
			res_city_q <= '0;
			res_last_q <= 1'b0;
			m_valid_q  <= 1'b0;
			m_city_q   <= '0;
			m_last_q   <= 1'b0;
		end else begin
			// row read pipeline: address issued now, data back in the next cycle
			v_s1 <= iss_act_q && ((state_q == S_SUM) || (state_q == S_WALK));
			j_s1 <= iss_q;
			if (iss_act_q) begin
				iss_q <= iss_q + CW'(1);
				// row end, or a pick ends the walk early
				if ((iss_q == CW'(CITIES - 1)) || ((state_q == S_WALK) && pick_now)) begin
					iss_act_q <= 1'b0;
				end
			end

			if (m_valid_q && m_axis_tready && !out_load) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					if (clr_idx_q == AW'(DEPTH - 1)) begin
						clr_idx_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						case (in_mode)
							MODE_CLEAR: begin
								in_tour_q <= 1'b0;
								state_q   <= S_CLEAR;
							end
							MODE_LEARN: begin
								prev_q   <= c_in;
								first_q  <= first_eff;
								addr_b_q <= pair_addr(c_in, first_eff);
								in_tour_q <= !s_axis_tlast;
								if (in_tour_q) begin
									addr_q   <= pair_addr(prev_q, c_in);
									pend_b_q <= s_axis_tlast;
									state_q  <= S_LRD;
								end else if (s_axis_tlast) begin
									// one-city tour: self pair
									addr_q   <= pair_addr(c_in, c_in);
									pend_b_q <= 1'b0;
									state_q  <= S_LRD;
								end
							end
							MODE_START: begin
								cur_q      <= c_in;
								visited_q  <= start_mask;
								res_city_q <= 3'(c_in);
								res_last_q <= (start_mask == {CITIES{1'b1}});
								state_q    <= S_DONE;
							end
							MODE_NEXT: begin
								rv_q <= s_axis_tdata[18:3];
								if (visited_q == {CITIES{1'b1}}) begin
									res_city_q <= '0;
									res_last_q <= 1'b1;
									state_q    <= S_DONE;
								end else begin
									iss_q      <= '0;
									iss_act_q  <= 1'b1;
									ff_found_q <= 1'b0;
									state_q    <= S_SUM;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LRD: begin
					state_q <= S_LWR;
				end
				S_LWR: begin
					if (pend_b_q) begin
						addr_q   <= addr_b_q;
						pend_b_q <= 1'b0;
						state_q  <= S_LRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SUM: begin
					if (unvisited_s1 && !ff_found_q) begin
						ff_q       <= j_s1;
						ff_found_q <= 1'b1;
					end
					if (v_s1 && (j_s1 == CW'(CITIES - 1))) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q    <= PW'(rv_q) * PW'(acc_sum);
					iss_q     <= '0;
					iss_act_q <= 1'b1;
					state_q   <= S_WALK;
				end
				S_WALK: begin
					if (pick_now) begin
						cur_q      <= pick_c;
						visited_q  <= visited_new;
						res_city_q <= 3'(pick_c);
						res_last_q <= (visited_new == {CITIES{1'b1}});
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						m_valid_q <= 1'b1;
						m_city_q  <= res_city_q;
						m_last_q  <= res_last_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, m_city_q};
	assign m_axis_tlast  = m_last_q;

	// a result is only published from the finish state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == S_DONE)
		else $error("output transfer raised outside finish state");

	// the walk never runs past its last row element
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && v_s1 && j_s1 == CW'(CITIES - 1)) |=> state_q == S_DONE)
		else $error("sampling walk ran past the row");

	// a finished sample always leaves the current city marked visited
	a_cur_visited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> visited_q[cur_q])
		else $error("current city not in visited mask");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// Tests for the edge-histogram tour model and sampler. A scoreboard keeps
// its own copy of the count table and the learn and sampling state, predicts
// every start and sample-next result as items are accepted, and compares each
// output transfer against the oldest prediction. Both stream sides idle at
// random.
module testbench;
	import emlts_pkg::*;

	localparam int CITY_N       = CITIES_DEF;
	localparam int COUNT_W      = COUNT_BITS_DEF;
	localparam int CNT_TOP      = (1 << COUNT_W) - 1;
	localparam longint RND_TOP  = (64'd1 << RANDOM_BITS) - 1;
	localparam int RANDOM_ITEMS = 875;
	// one-city tours of city 0, enough to push its self count past the top
	localparam int SAT_ITEMS    = CNT_TOP + 8;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 2000000;

	typedef struct packed {
		logic [2:0] city;
		logic       complete;
	} tour_step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // city[2:0], random_value[18:3], zero fill
	logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
	logic        s_axis_tlast = 1'b0; // tour_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // chosen_city[2:0], zero fill
	logic        m_axis_tlast;        // tour_complete

	edge_model_learn_and_tour_sample u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	// scoreboard copy of the block state
	logic [COUNT_W-1:0] edge_hits [CITY_N*CITY_N];
	logic [2:0]         learn_head;
	logic [2:0]         learn_prev;
	logic               learn_open;
	logic [2:0]         walk_city;
	logic [CITY_N-1:0]  walk_seen;

	tour_step_t due_steps[$];   // predicted output transfers, oldest first
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         gaps_on = 1'b1; // random idling on both sides
	int         hold_request = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[edge_model_learn_and_tour_sample] ERROR");
		$finish;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic void clear_hits();
		for (int k = 0; k < CITY_N * CITY_N; k++)
			edge_hits[k] = COUNT_W'(1);
	endfunction

	function automatic void bump_edge(logic [2:0] from, logic [2:0] to);
		int k;
		k = from * CITY_N + to;
		if (edge_hits[k] != CNT_TOP)
			edge_hits[k] = edge_hits[k] + 1'b1;
	endfunction

	// Advance the scoreboard by one accepted item; queue the result it causes.
	function automatic void advance_tour_model(mode_t m, logic [2:0] c, logic last,
			logic [15:0] rv);
		tour_step_t     step;
		longint unsigned total, cum;
		int             pick;
		bit             found;
		case (m)
			MODE_CLEAR: begin
				clear_hits();
				learn_open = 1'b0;
			end
			MODE_LEARN: begin
				if (!learn_open) begin
					learn_head = c;
					learn_open = 1'b1;
				end else begin
					bump_edge(learn_prev, c);
				end
				learn_prev = c;
				// tour end closes the loop back to the first city
				if (last) begin
					bump_edge(c, learn_head);
					learn_open = 1'b0;
				end
			end
			MODE_START: begin
				walk_city = c;
				walk_seen = '0;
				walk_seen[c] = 1'b1;
				step.city = c;
				step.complete = &walk_seen;
				due_steps.push_back(step);
			end
			default: begin
				if (&walk_seen) begin
					// nothing left to visit: city 0, state untouched
					step.city = '0;
					step.complete = 1'b1;
				end else begin
					total = 0;
					pick = 0;
					for (int j = CITY_N - 1; j >= 0; j--) begin
						if (!walk_seen[j]) begin
							total += edge_hits[walk_city * CITY_N + j];
							pick = j;   // first unvisited city as fallback
						end
					end
					// cumulative walk: first j with rv/RND_TOP <= cum/total
					cum = 0;
					found = 1'b0;
					for (int j = 0; j < CITY_N; j++) begin
						if (!walk_seen[j] && !found) begin
							cum += edge_hits[walk_city * CITY_N + j];
							if (longint'(rv) * total <= cum * RND_TOP) begin
								pick = j;
								found = 1'b1;
							end
						end
					end
					walk_seen[pick] = 1'b1;
					walk_city = pick[2:0];
					step.city = pick[2:0];
					step.complete = &walk_seen;
				end
				due_steps.push_back(step);
			end
		endcase
	endfunction

	// One input transfer; valid stays up if the next item follows at once.
	task automatic send_item(mode_t m, logic [2:0] c, logic last, logic [15:0] rv);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= {5'b0, rv, c};
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		advance_tour_model(m, c, last, rv);
	endtask

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				m_axis_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Output check against the oldest prediction.
	always @(posedge clk) begin
		tour_step_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_steps.size() == 0) begin
				report_mismatch("unexpected result, chosen_city",
					int'(m_axis_tdata[2:0]), 0);
			end else begin
				want = due_steps.pop_front();
				if (m_axis_tdata[2:0] !== want.city)
					report_mismatch("chosen_city", int'(m_axis_tdata[2:0]),
						int'(want.city));
				if (m_axis_tlast !== want.complete)
					report_mismatch("tour_complete", int'(m_axis_tlast),
						int'(want.complete));
			end
		end
	end

	// Self count of city 0 driven past the ceiling, then sampled from the
	// reset state (city 0 current, nothing visited): a held count keeps
	// city 0 for this fraction, a wrapped one would not.
	task automatic test_count_saturation();
		for (int k = 0; k < SAT_ITEMS; k++)
			send_item(MODE_LEARN, 3'd0, 1'b1, 16'($urandom_range(0, 65535)));
		send_item(MODE_NEXT, 3'd0, 1'b0, 16'hF000);
	endtask

	// Sampling with no start item uses the current city and mask as they stand.
	task automatic test_sample_from_reset();
		send_item(MODE_NEXT, 3'd5, 1'b1, 16'hFFFF);  // top fraction: last unvisited
		send_item(MODE_NEXT, 3'd2, 1'b0, 16'h0000);  // zero fraction: first unvisited
	endtask

	// Walk every city, then sample once more with all visited.
	task automatic test_full_tour();
		send_item(MODE_START, 3'd3, 1'b1, 16'hAAAA);
		for (int k = 0; k < CITY_N; k++)
			send_item(MODE_NEXT, 3'(k), k[0],
				(k % 3 == 0) ? 16'h0000 : (k % 3 == 1) ? 16'hFFFF : 16'h5555);
		send_item(MODE_START, 3'd7, 1'b0, 16'h0001);
		send_item(MODE_NEXT, 3'd0, 1'b0, 16'h8000);
	endtask

	// One-city tour, a short tour, a new tour after an end, clear mid tour.
	task automatic test_learn_cases();
		send_item(MODE_LEARN, 3'd6, 1'b1, 16'h1234);  // self edge only
		send_item(MODE_LEARN, 3'd2, 1'b0, 16'h0000);
		send_item(MODE_LEARN, 3'd5, 1'b0, 16'hFFFF);
		send_item(MODE_LEARN, 3'd1, 1'b1, 16'h0F0F);  // closes 1 -> 2
		send_item(MODE_LEARN, 3'd4, 1'b0, 16'hF0F0);  // new tour
		send_item(MODE_CLEAR, 3'd7, 1'b1, 16'hFFFF);  // abandons it
		send_item(MODE_LEARN, 3'd0, 1'b1, 16'h0000);  // fresh first city
		send_item(MODE_START, 3'd2, 1'b0, 16'h0000);
		send_item(MODE_NEXT, 3'd0, 1'b0, 16'h7FFF);
	endtask

	// Receiver holds off while back-to-back samples fill the block.
	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		hold_request = 300;
		send_item(MODE_START, 3'($urandom_range(0, 7)), 1'b0,
			16'($urandom_range(0, 65535)));
		for (int k = 0; k < 20; k++)
			send_item(MODE_NEXT, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
				16'($urandom_range(0, 65535)));
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed learn tours and sample walks, some clears and noise.
	task automatic test_random_mix();
		int sent, len, pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				gaps_on = !gaps_on;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
					: $urandom_range(1, 8);
				for (int k = 0; k < len; k++)
					send_item(MODE_LEARN, 3'($urandom_range(0, 7)), k == len - 1,
						16'($urandom_range(0, 65535)));
				sent += len;
			end else if (pick < 83) begin
				len = $urandom_range(0, 9);
				send_item(MODE_START, 3'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
				for (int k = 0; k < len; k++)
					send_item(MODE_NEXT, 3'($urandom_range(0, 7)),
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
				sent += len + 1;
			end else if (pick < 86) begin
				send_item(MODE_CLEAR, 3'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
				sent++;
			end else begin
				send_item(mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
				sent++;
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		clear_hits();
		learn_head = '0;
		learn_prev = '0;
		learn_open = 1'b0;
		walk_city  = '0;
		walk_seen  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_count_saturation();
		test_sample_from_reset();
		test_full_tour();
		test_learn_cases();
		test_output_backpressure();
		test_random_mix();
		s_axis_tvalid <= 1'b0;

		// drain, then watch for stray transfers
		while (due_steps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("[edge_model_learn_and_tour_sample] OK");
		else
			$display("[edge_model_learn_and_tour_sample] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/emlts_pkg.sv
design/emlts_ram.sv
design/emlts_acc.sv
design/edge_model_learn_and_tour_sample.sv
sim/testbench.sv
